/* design/urtb_pkg.sv */
package urtb_pkg;

   localparam int RX_DEPTH = 32;
   localparam int TX_DEPTH = 32;
   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int TX_PTR_W = $clog2(TX_DEPTH);

   localparam logic [15:0] TIMEOUT_RESET = 16'd1275;

   typedef enum logic [2:0] {
      OP_RX_BYTE    = 3'd0,
      OP_HOST_WRITE = 3'd1,
      OP_TX_DONE    = 3'd2,
      OP_HOST_READ  = 3'd3,
      OP_TICK       = 3'd4,
      OP_FLUSH      = 3'd5
   } op_type;

   typedef enum logic {
      CSR_TX_BUFFERED  = 1'b0,
      CSR_READ_TIMEOUT = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic        tx_buffered;
      logic [15:0] read_timeout;
   } cfg_type;

   typedef struct packed {
      logic       read_valid;
      logic [7:0] read_data;
      logic       timed_out;
      logic       rx_available;
   } rx_result_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_data;
      logic       transmitter_idle;
   } tx_result_type;

   function automatic logic [RX_PTR_W-1:0] rx_ptr_inc(input logic [RX_PTR_W-1:0] p);
      return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [TX_PTR_W-1:0] tx_ptr_inc(input logic [TX_PTR_W-1:0] p);
      return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

/* design/uart_rx_tx_ring_buffers.sv */
// UART receive and transmit ring buffers. Each request transaction carries an
// operation in req_tuser (received line byte, host write, transmit done, host
// read, timer tick, flush) and a byte in req_tdata, and produces exactly one
// response transaction with the read result, any byte handed to the line
// transmitter, and the receive-available and transmitter-idle levels. One
// transaction is taken every clock cycle while responses are accepted. The
// request is registered, the ring update for it is computed from that
// register, and the result is held in an output register that lets the next
// request in while a response waits. Both rings hold 32 bytes with no
// overflow check: 32 unread bytes make a ring look empty. A read of an empty
// receive ring waits for read_timeout tick operations, or until a byte arrives,
// and a timeout returns zero with timed_out set. Configuration registers are
// at csr_paddr 0 (tx_buffered) and 4 (read_timeout, reset 1275); the user must
// write them only while no transaction is in flight (the block does not check).
module uart_rx_tx_ring_buffers import urtb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data
   input  logic [2:0]  req_tuser,   // [2:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] read_valid, [8:1] read_data, [9] timed_out, [10] send_valid,
   // [18:11] send_data, [19] rx_available, [20] transmitter_idle, [23:21] zero
   output logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   item_type      item_ff;
   logic          in_valid_ff;
   logic [23:0]   rsp_data_ff;
   logic          rsp_valid_ff;
   logic          advance;
   cfg_type       cfg;
   rx_result_type rx_result;
   tx_result_type tx_result;

   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   urtb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   urtb_rx u_rx (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (item_ff),
      .read_timeout (cfg.read_timeout),
      .result       (rx_result)
   );

   urtb_tx u_tx (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (item_ff),
      .tx_buffered (cfg.tx_buffered),
      .result      (tx_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.operation <= op_type'(req_tuser);
         item_ff.data      <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {3'd0,
                         tx_result.transmitter_idle,
                         rx_result.rx_available,
                         tx_result.send_data,
                         tx_result.send_valid,
                         rx_result.timed_out,
                         rx_result.read_data,
                         rx_result.read_valid};
      end
   end

endmodule

/* design/urtb_csr.sv */
module urtb_csr import urtb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign index      = csr_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      case (index)
         CSR_TX_BUFFERED: begin
            csr_prdata = {31'd0, cfg_ff.tx_buffered};
            if (write_en) begin
               cfg_in.tx_buffered = csr_pwdata[0];
            end
         end
         CSR_READ_TIMEOUT: begin
            csr_prdata = {16'd0, cfg_ff.read_timeout};
            if (write_en) begin
               cfg_in.read_timeout = csr_pwdata[15:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tx_buffered  <= 1'b0;
         cfg_ff.read_timeout <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/urtb_rx.sv */
module urtb_rx import urtb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  item_type      item,
   input  logic [15:0]   read_timeout,
   output rx_result_type result
);

   logic [7:0]          store_ff [RX_DEPTH];
   logic [RX_PTR_W-1:0] wr_ptr_ff;
   logic [RX_PTR_W-1:0] wr_ptr_in;
   logic [RX_PTR_W-1:0] rd_ptr_ff;
   logic [RX_PTR_W-1:0] rd_ptr_in;
   logic                waiting_ff;
   logic                waiting_in;
   logic [15:0]         ticks_ff;
   logic [15:0]         ticks_in;
   logic                store_we;
   logic [7:0]          head;

   // the head entry may be the one written by this same transaction
   assign head = (rd_ptr_ff == wr_ptr_ff) ? item.data : store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      waiting_in = waiting_ff;
      ticks_in   = ticks_ff;
      store_we   = 1'b0;
      result     = '0;
      case (item.operation)
         OP_RX_BYTE: begin
            store_we  = 1'b1;
            wr_ptr_in = rx_ptr_inc(wr_ptr_ff);
            if (waiting_ff && (wr_ptr_in != rd_ptr_ff)) begin
               result.read_valid = 1'b1;
               result.read_data  = head;
               rd_ptr_in         = rx_ptr_inc(rd_ptr_ff);
               waiting_in        = 1'b0;
               ticks_in          = '0;
            end
         end
         OP_HOST_READ: begin
            if (wr_ptr_ff != rd_ptr_ff) begin
               result.read_valid = 1'b1;
               result.read_data  = store_ff[rd_ptr_ff];
               rd_ptr_in         = rx_ptr_inc(rd_ptr_ff);
               waiting_in        = 1'b0;
               ticks_in          = '0;
            end else if (read_timeout == '0) begin
               result.read_valid = 1'b1;
               result.timed_out  = 1'b1;
               waiting_in        = 1'b0;
               ticks_in          = '0;
            end else begin
               waiting_in = 1'b1;
               ticks_in   = read_timeout;
            end
         end
         OP_TICK: begin
            if (waiting_ff) begin
               ticks_in = ticks_ff - 16'd1;
               if (ticks_in == '0) begin
                  result.read_valid = 1'b1;
                  result.timed_out  = 1'b1;
                  waiting_in        = 1'b0;
               end
            end
         end
         OP_FLUSH: begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
         end
         default: begin
            store_we = 1'b0;
         end
      endcase
      result.rx_available = (wr_ptr_in != rd_ptr_in);
   end

   always_ff @(posedge clock) begin
      if (advance && store_we) begin
         store_ff[wr_ptr_ff] <= item.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         waiting_ff <= 1'b0;
         ticks_ff   <= '0;
      end else if (advance) begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         waiting_ff <= waiting_in;
         ticks_ff   <= ticks_in;
      end
   end

endmodule

/* design/urtb_tx.sv */
module urtb_tx import urtb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  item_type      item,
   input  logic          tx_buffered,
   output tx_result_type result
);

   logic [7:0]          store_ff [TX_DEPTH];
   logic [TX_PTR_W-1:0] wr_ptr_ff;
   logic [TX_PTR_W-1:0] wr_ptr_in;
   logic [TX_PTR_W-1:0] rd_ptr_ff;
   logic [TX_PTR_W-1:0] rd_ptr_in;
   logic                idle_ff;
   logic                idle_in;
   logic                store_we;
   logic [7:0]          head;

   // the head entry may be the one written by this same transaction
   assign head = (rd_ptr_ff == wr_ptr_ff) ? item.data : store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      idle_in   = idle_ff;
      store_we  = 1'b0;
      result    = '0;
      case (item.operation)
         OP_HOST_WRITE: begin
            if (!tx_buffered) begin
               result.send_valid = 1'b1;
               result.send_data  = item.data;
            end else begin
               store_we  = 1'b1;
               wr_ptr_in = tx_ptr_inc(wr_ptr_ff);
               if (idle_ff) begin
                  if (rd_ptr_ff != wr_ptr_in) begin
                     idle_in           = 1'b0;
                     result.send_valid = 1'b1;
                     result.send_data  = head;
                     rd_ptr_in         = tx_ptr_inc(rd_ptr_ff);
                  end else begin
                     idle_in = 1'b1;
                  end
               end
            end
         end
         OP_TX_DONE: begin
            if (tx_buffered) begin
               if (rd_ptr_ff != wr_ptr_ff) begin
                  result.send_valid = 1'b1;
                  result.send_data  = store_ff[rd_ptr_ff];
                  rd_ptr_in         = tx_ptr_inc(rd_ptr_ff);
               end else begin
                  idle_in = 1'b1;
               end
            end
         end
         default: begin
            store_we = 1'b0;
         end
      endcase
      result.transmitter_idle = idle_in;
   end

   always_ff @(posedge clock) begin
      if (advance && store_we) begin
         store_ff[wr_ptr_ff] <= item.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         idle_ff   <= 1'b1;
      end else if (advance) begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         idle_ff   <= idle_in;
      end
   end

endmodule
